### rtl/core/saef_pkg.sv
// Shared constants, types and codes of the scanline adaptive edge finder.
package saef_pkg;

  localparam int WIN_TAPS = 8;
  localparam int LIST_CAP = 1024;
  localparam int LINE_MAX = 4096;

  localparam int KIND_W = 2;
  localparam int PIX_W  = 8;
  localparam int Y_W    = 12;
  localparam int X_W    = 12;
  localparam int IDX_W  = 10;
  localparam int FRAC_W = 8;

  localparam int SLOT_W = $clog2(WIN_TAPS);
  localparam int SUM_W  = PIX_W + $clog2(WIN_TAPS);
  localparam int COL_W  = $clog2(LINE_MAX + 1);
  localparam int CNT_W  = $clog2(LIST_CAP);
  localparam int PROD_W = PIX_W + FRAC_W;

  localparam int S_DATA_W = ((PIX_W + Y_W + 7) / 8) * 8;
  localparam int EDGE_W   = 1 + X_W + Y_W + PIX_W + IDX_W;
  localparam int M_DATA_W = ((EDGE_W + 7) / 8) * 8;

  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(64);

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PIXEL,
    OP_LINE,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic [Y_W-1:0]    row;
    logic [PIX_W-1:0]  pixel;
  } item_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } ram_wr_t;

endpackage

### rtl/core/saef_win_ram.sv
// Boxcar window memory: one write port, one read port with registered read data.
module saef_win_ram (
  input  logic                           clk_i,
  input  saef_pkg::ram_wr_t              wr_i,
  input  logic                           re_i,
  input  logic [saef_pkg::SLOT_W-1:0]    raddr_i,
  output logic [saef_pkg::PIX_W-1:0]     rdata_o
);

  logic [saef_pkg::PIX_W-1:0] mem_q [saef_pkg::WIN_TAPS];
  logic [saef_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/saef_detect.sv
// Second stage: running sum, adaptive band, hysteresis, edge count and output register.
module saef_detect (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  input  saef_pkg::item_t                item_i,
  output logic                           item_ready_o,
  input  logic [saef_pkg::PIX_W-1:0]     rdata_i,
  input  logic [saef_pkg::FRAC_W-1:0]    frac_i,
  output saef_pkg::ram_wr_t              wr_o,
  output logic                           edge_valid_o,
  output logic [saef_pkg::M_DATA_W-1:0]  edge_data_o,
  input  logic                           edge_ready_i
);

  logic                           s1_valid_q, s1_valid_d;
  saef_pkg::item_t                s1_q;
  logic [saef_pkg::SUM_W-1:0]     sum_q, sum_d;
  logic                           above_q, above_d;
  logic [saef_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;
  logic [saef_pkg::M_DATA_W-1:0]  out_data_q;

  logic                           adv;
  logic                           fill;
  logic [saef_pkg::PIX_W-1:0]     old_pix;
  logic [saef_pkg::PIX_W-1:0]     avg;
  logic [saef_pkg::PROD_W-1:0]    prod;
  logic [saef_pkg::PIX_W-1:0]     thr;
  logic [saef_pkg::PIX_W:0]       hi;
  logic [saef_pkg::PIX_W-1:0]     lo;
  logic                           is_pix;
  logic                           rise;
  logic                           fall;
  logic                           room;
  logic                           emit;

  assign adv          = s1_valid_q && (!out_valid_q || edge_ready_i);
  assign item_ready_o = !s1_valid_q || adv;
  assign is_pix       = (s1_q.op == saef_pkg::OP_PIXEL);

  always_comb begin
    fill    = s1_q.col < saef_pkg::COL_W'(saef_pkg::WIN_TAPS);
    old_pix = fill ? '0 : rdata_i;
    avg     = saef_pkg::PIX_W'(sum_q / saef_pkg::WIN_TAPS);
    prod    = saef_pkg::PROD_W'(avg) * saef_pkg::PROD_W'(frac_i);
    thr     = prod[saef_pkg::PROD_W-1:saef_pkg::FRAC_W];
    hi      = {1'b0, avg} + {1'b0, thr};
    lo      = (avg < thr) ? '0 : avg - thr;
    rise    = is_pix && !fill && !above_q && ({1'b0, s1_q.pixel} > hi);
    fall    = is_pix && !fill && above_q && !({1'b0, s1_q.pixel} > hi) && (s1_q.pixel < lo);
    room    = cnt_q < saef_pkg::CNT_W'(saef_pkg::LIST_CAP - 1);
    emit    = adv && (rise || fall) && room;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (item_valid_i) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    sum_d   = sum_q;
    above_d = above_q;
    cnt_d   = cnt_q;
    if (adv) begin
      unique case (s1_q.op)
        saef_pkg::OP_PIXEL: begin
          sum_d = sum_q - saef_pkg::SUM_W'(old_pix) + saef_pkg::SUM_W'(s1_q.pixel);
          if (rise) begin
            above_d = 1'b1;
          end else if (fall) begin
            above_d = 1'b0;
          end
          if (emit) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        saef_pkg::OP_LINE: begin
          sum_d   = '0;
          above_d = 1'b0;
        end
        saef_pkg::OP_CLEAR: begin
          cnt_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (edge_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    wr_o.we   = adv && is_pix;
    wr_o.addr = s1_q.slot;
    wr_o.data = s1_q.pixel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      sum_q       <= '0;
      above_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      sum_q       <= sum_d;
      above_q     <= above_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      s1_q <= item_i;
    end
    if (emit) begin
      out_data_q <= saef_pkg::M_DATA_W'({saef_pkg::IDX_W'(cnt_q), s1_q.pixel, s1_q.row,
                                         saef_pkg::X_W'(s1_q.col), fall});
    end
  end

  assign edge_valid_o = out_valid_q;
  assign edge_data_o  = out_data_q;

endmodule

### rtl/core/scanline_adaptive_edge_finder.sv
// Top level of the scanline adaptive edge finder: input decode, line position, window memory.
//
// Input words arrive on s_axis: tuser carries the kind (pixel, line start,
// clear edge list count), tdata the pixel and the row of a new line.
// Edge words leave on m_axis, one per detected edge that fits the list.
// threshold_frac is written through cfg_we_i/cfg_wdata_i; write it only while the block is
// idle (not enforced here); it resets to 64 (a band of one quarter of the local mean).
// An edge word reaches m_axis as follows: the accept edge registers the word and the window
// memory read; the second stage then updates the running sum, tests the band against the
// registered read data and, when it advances, loads the edge word into the output register.
// One word is accepted every cycle unless m_axis stalls; the window memory has one read
// and one write port, and a slot is read again only WIN_TAPS pixels after its write.
// When m_axis stalls, the output register holds its edge, the second stage
// holds its word, and s_axis_tready drops only once both are full.
// Reset clears the line position, row, running sum, band state, edge count
// and valid flags; the window memory is not cleared, the first WIN_TAPS
// pixels of each line read as zero instead.
module scanline_adaptive_edge_finder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [saef_pkg::FRAC_W-1:0]    cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [saef_pkg::S_DATA_W-1:0]  s_axis_tdata,  // pixel[7:0], line_y[19:8], zero fill
  input  logic [saef_pkg::KIND_W-1:0]    s_axis_tuser,  // kind[1:0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [saef_pkg::M_DATA_W-1:0]  m_axis_tdata   // polarity[0], x_position[12:1],
                                                        // y_position[24:13], edge_pixel[32:25],
                                                        // list_index[42:33], zero fill
);

  logic [saef_pkg::FRAC_W-1:0]  frac_q;
  logic [saef_pkg::COL_W-1:0]   col_q, col_d;
  logic [saef_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic [saef_pkg::Y_W-1:0]     row_q, row_d;

  logic                         accept;
  logic                         item_ready;
  saef_pkg::item_t              item;
  saef_pkg::ram_wr_t            ram_wr;
  logic                         ram_re;
  logic [saef_pkg::PIX_W-1:0]   ram_rdata;
  logic [saef_pkg::PIX_W-1:0]   in_pixel;
  logic [saef_pkg::Y_W-1:0]     in_line_y;

  assign in_pixel      = s_axis_tdata[saef_pkg::PIX_W-1:0];
  assign in_line_y     = s_axis_tdata[saef_pkg::PIX_W+saef_pkg::Y_W-1:saef_pkg::PIX_W];
  assign s_axis_tready = item_ready;
  assign accept        = s_axis_tvalid && item_ready;

  always_comb begin
    item.op    = saef_pkg::OP_NONE;
    item.col   = col_q;
    item.slot  = slot_q;
    item.row   = row_q;
    item.pixel = in_pixel;
    unique case (saef_pkg::kind_e'(s_axis_tuser))
      saef_pkg::KIND_PIXEL: begin
        if (col_q < saef_pkg::COL_W'(saef_pkg::LINE_MAX)) begin
          item.op = saef_pkg::OP_PIXEL;
        end
      end
      saef_pkg::KIND_LINE:  item.op = saef_pkg::OP_LINE;
      saef_pkg::KIND_CLEAR: item.op = saef_pkg::OP_CLEAR;
      default:              item.op = saef_pkg::OP_NONE;
    endcase
  end

  assign ram_re = accept && (item.op == saef_pkg::OP_PIXEL);

  always_comb begin
    col_d  = col_q;
    slot_d = slot_q;
    row_d  = row_q;
    if (accept) begin
      if (item.op == saef_pkg::OP_PIXEL) begin
        col_d  = col_q + 1'b1;
        slot_d = (slot_q == saef_pkg::SLOT_W'(saef_pkg::WIN_TAPS - 1)) ? '0 : slot_q + 1'b1;
      end else if (item.op == saef_pkg::OP_LINE) begin
        col_d  = '0;
        slot_d = '0;
        row_d  = in_line_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= saef_pkg::FRAC_RESET;
      col_q  <= '0;
      slot_q <= '0;
      row_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        frac_q <= cfg_wdata_i;
      end
      col_q  <= col_d;
      slot_q <= slot_d;
      row_q  <= row_d;
    end
  end

  saef_win_ram u_win_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .re_i    (ram_re),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  saef_detect u_detect (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (accept),
    .item_i       (item),
    .item_ready_o (item_ready),
    .rdata_i      (ram_rdata),
    .frac_i       (frac_q),
    .wr_o         (ram_wr),
    .edge_valid_o (m_axis_tvalid),
    .edge_data_o  (m_axis_tdata),
    .edge_ready_i (m_axis_tready)
  );

  a_no_slot_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_wr.we && ram_re && (ram_wr.addr == slot_q)))
    else $error("window read and write hit the same slot");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= saef_pkg::COL_W'(saef_pkg::LINE_MAX))
    else $error("column ran past the line limit");

  a_line_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item.op == saef_pkg::OP_LINE)) |=> (col_q == '0) && (slot_q == '0))
    else $error("line start did not rewind column and slot");

endmodule

### tb/edge_list_checker.sv
// Checker for the scanline edge finder: predicts edge words from accepted input words and compares.
module edge_list_checker
  import saef_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [FRAC_W-1:0]   cfg_wdata_i,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [S_DATA_W-1:0] s_data_i,
  input  logic [KIND_W-1:0]   s_kind_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [M_DATA_W-1:0] m_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  edges_checked_o
);

  typedef struct {
    logic             pol;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [PIX_W-1:0] pix;
    logic [IDX_W-1:0] idx;
  } edge_word_t;

  localparam int X_LSB   = 1;
  localparam int Y_LSB   = X_LSB + X_W;
  localparam int PIX_LSB = Y_LSB + Y_W;
  localparam int IDX_LSB = PIX_LSB + PIX_W;

  edge_word_t       awaited_edges[$];
  logic [PIX_W-1:0] win [WIN_TAPS];
  logic [SUM_W-1:0] win_sum;
  logic [COL_W-1:0] col;
  logic             above;
  logic [Y_W-1:0]   row;
  logic [CNT_W-1:0] n_edges;
  logic [FRAC_W-1:0] frac;

  task automatic clear_line();
    foreach (win[i]) win[i] = '0;
    win_sum = '0;
    col     = '0;
    above   = 1'b0;
  endtask

  task automatic predict_edge(input logic [KIND_W-1:0] kind, input logic [PIX_W-1:0] pix,
                              input logic [Y_W-1:0] y);
    int unsigned       mean, band, hi, lo;
    logic [SLOT_W-1:0] slot;
    logic              pol, hit;
    edge_word_t        w;
    hit = 1'b0;
    pol = 1'b0;
    if (kind == KIND_LINE) begin
      clear_line();
      row = y;
    end else if (kind == KIND_CLEAR) begin
      n_edges = '0;
    end else if (kind == KIND_PIXEL && col < LINE_MAX) begin
      slot = col[SLOT_W-1:0];
      if (col >= WIN_TAPS) begin
        mean = win_sum / WIN_TAPS;
        band = (mean * frac) >> 8;
        hi   = mean + band;
        lo   = (mean < band) ? 0 : mean - band;
        if (pix > hi) begin
          if (!above) begin
            above = 1'b1;
            hit   = 1'b1;
            pol   = 1'b0;
          end
        end else if (pix < lo) begin
          if (above) begin
            above = 1'b0;
            hit   = 1'b1;
            pol   = 1'b1;
          end
        end
        if (hit && n_edges < LIST_CAP - 1) begin
          w.pol = pol;
          w.x   = col[X_W-1:0];
          w.y   = row;
          w.pix = pix;
          w.idx = n_edges;
          awaited_edges.push_back(w);
          n_edges++;
        end
      end
      win_sum   = win_sum - win[slot] + pix;
      win[slot] = pix;
      col++;
    end
  endtask

  function automatic int field_bad(string name, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $display("%0t edge %s mismatch: expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    edge_word_t want;
    int         bad;
    if (!rst_ni) begin
      clear_line();
      row             = '0;
      n_edges         = '0;
      frac            = FRAC_RESET;
      fail_count_o    = 0;
      edges_checked_o = 0;
      awaited_edges.delete();
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (awaited_edges.size() == 0) begin
          $display("%0t unexpected edge word: expected none, got %h", $time, m_data_i);
          fail_count_o++;
        end else begin
          want = awaited_edges.pop_front();
          bad  = field_bad("polarity", want.pol, m_data_i[0]);
          bad += field_bad("x_position", want.x, m_data_i[X_LSB +: X_W]);
          bad += field_bad("y_position", want.y, m_data_i[Y_LSB +: Y_W]);
          bad += field_bad("edge_pixel", want.pix, m_data_i[PIX_LSB +: PIX_W]);
          bad += field_bad("list_index", want.idx, m_data_i[IDX_LSB +: IDX_W]);
          if (bad != 0) fail_count_o++;
          edges_checked_o++;
        end
      end
      if (s_valid_i && s_ready_i) begin
        predict_edge(s_kind_i, s_data_i[PIX_W-1:0], s_data_i[PIX_W +: Y_W]);
      end
      if (cfg_we_i) frac = cfg_wdata_i;
    end
    pending_o = awaited_edges.size();
  end

endmodule

### tb/tb.sv
// Testbench top for the scanline edge finder: reset, stimulus, handshake idling and verdict.
module tb;
  import saef_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [FRAC_W-1:0]   cfg_wdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [KIND_W-1:0]   s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  logic s_fire = 1'b0;
  logic steady = 1'b1;
  int   fails, pending, edges_checked;
  int   words_sent = 0;
  int   settings_used = 1;
  int   rx_hold = 0;
  int   rx_pick;

  always #5 clk_i = ~clk_i;

  scanline_adaptive_edge_finder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  edge_list_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_valid_i       (s_axis_tvalid),
    .s_ready_i       (s_axis_tready),
    .s_data_i        (s_axis_tdata),
    .s_kind_i        (s_axis_tuser),
    .m_valid_i       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_data_i        (m_axis_tdata),
    .fail_count_o    (fails),
    .pending_o       (pending),
    .edges_checked_o (edges_checked)
  );

  always @(posedge clk_i) s_fire <= s_axis_tvalid && s_axis_tready;

  // outside steady mode, stall the edge output: mostly short runs, a few long ones
  always @(negedge clk_i) begin
    if (steady) begin
      m_axis_tready = 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 55) begin
        m_axis_tready = 1'b1;
        rx_hold = $urandom_range(1, 20);
      end else if (rx_pick < 90) begin
        m_axis_tready = 1'b0;
        rx_hold = $urandom_range(1, 3);
      end else begin
        m_axis_tready = 1'b0;
        rx_hold = $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [PIX_W-1:0] pix,
                           input logic [Y_W-1:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = S_DATA_W'({y, pix});
    do @(negedge clk_i); while (!s_fire);
    if (kind != KIND_UNUSED) words_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_frac(input logic [FRAC_W-1:0] value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    settings_used++;
  endtask

  task automatic random_phase(input int n);
    int sent, r, level, p;
    sent  = 0;
    level = $urandom_range(0, 255);
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_word(KIND_CLEAR, PIX_W'($urandom), Y_W'($urandom));
        sent++;
      end else if (r < 6) begin
        send_word(KIND_UNUSED, PIX_W'($urandom), Y_W'($urandom));
      end else if (r < 11) begin
        send_word(KIND_LINE, PIX_W'($urandom), Y_W'($urandom));
        sent++;
      end else begin
        if ($urandom_range(0, 4) == 0) level = $urandom_range(0, 255);
        if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 255);
        else p = level + $urandom_range(0, 12) - 6;
        if (p < 0) p = 0;
        if (p > 255) p = 255;
        send_word(KIND_PIXEL, PIX_W'(p), Y_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // pixels before any line start land on row zero
    repeat (WIN_TAPS) send_word(KIND_PIXEL, 8'd100, Y_W'($urandom));
    send_word(KIND_PIXEL, 8'd255, Y_W'($urandom));
    send_word(KIND_PIXEL, 8'd0, Y_W'($urandom));
    send_word(KIND_UNUSED, 8'd255, 12'hfff);
    send_word(KIND_CLEAR, PIX_W'($urandom), Y_W'($urandom));
    send_word(KIND_LINE, PIX_W'($urandom), 12'hfff);
    repeat (WIN_TAPS + 1) send_word(KIND_PIXEL, 8'd0, Y_W'($urandom));
    send_word(KIND_PIXEL, 8'd1, Y_W'($urandom));
    send_word(KIND_LINE, PIX_W'($urandom), 12'h000);

    write_frac(8'd0);
    steady = 1'b0;
    random_phase(75);
    write_frac(8'd255);
    random_phase(75);
    write_frac(8'd1);
    random_phase(75);
    write_frac(8'd128);
    steady = 1'b1;
    random_phase(75);
    steady = 1'b0;
    write_frac(FRAC_W'($urandom_range(0, 255)));
    random_phase(75);

    // full swings with a zero band after a fresh line and a cleared list
    write_frac(8'd0);
    send_word(KIND_CLEAR, PIX_W'($urandom), Y_W'($urandom));
    send_word(KIND_LINE, PIX_W'($urandom), Y_W'($urandom));
    for (int i = 0; i < 2 * WIN_TAPS; i++) begin
      send_word(KIND_PIXEL, (i % 2 == 0) ? 8'd255 : 8'd0, Y_W'($urandom));
    end
    write_frac(FRAC_RESET);
    random_phase(35);

    wait_idle();
    $display("Sent %0d input words over %0d threshold settings and checked %0d edge words,",
             words_sent, settings_used, edges_checked);
    $display("with line starts, list clears, unused kinds, pixels before the first line "
             , "and stalls on both sides.");
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
rtl/core/saef_pkg.sv
rtl/core/saef_win_ram.sv
rtl/core/saef_detect.sv
rtl/core/scanline_adaptive_edge_finder.sv
tb/edge_list_checker.sv
tb/tb.sv
